// File: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_EQ  = 3'd4,
        MODE_NE  = 3'd5,
        MODE_NEG = 3'd6,
        MODE_NOP = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture inputs
        logic mul;       // form cross products
        logic gcd_step;  // one gcd step (subtract/shift)
        logic div_init;  // start a division by the gcd
        logic div_step;  // one restoring-division bit
        logic div_sel_d; // 0: divide numerator, 1: denominator
        logic finish;    // form the result fields
    } rau_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic early;     // result known without reduction
        logic gcd_done;
        logic div_done;
    } rau_stat_t;

endpackage

// File: rtl/core/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: load, multiply, gcd loop, two divisions, hold the result.
// ----------------------------------------------------------------------------
module rau_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rau_pkg::rau_stat_t  stat,
    output rau_pkg::rau_cmd_t   cmd
);

    rau_pkg::state_t state_reg;
    rau_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rau_pkg::S_MUL;
                end
            end
            rau_pkg::S_MUL:
            begin
                state_next = stat.early ? rau_pkg::S_DONE : rau_pkg::S_GCD;
            end
            rau_pkg::S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    state_next = rau_pkg::S_DIVN;
                end
            end
            rau_pkg::S_DIVN:
            begin
                if (stat.div_done)
                begin
                    state_next = rau_pkg::S_DIVD;
                end
            end
            rau_pkg::S_DIVD:
            begin
                if (stat.div_done)
                begin
                    state_next = rau_pkg::S_DONE;
                end
            end
            rau_pkg::S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = rau_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rau_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            rau_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rau_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            rau_pkg::S_GCD:
            begin
                cmd.gcd_step = !stat.gcd_done;
                cmd.div_init = stat.gcd_done;
            end
            rau_pkg::S_DIVN:
            begin
                cmd.div_step = !stat.div_done;
                cmd.div_init = stat.div_done;
                cmd.div_sel_d = stat.div_done;
            end
            rau_pkg::S_DIVD:
            begin
                cmd.div_sel_d = 1'b1;
                cmd.div_step  = !stat.div_done;
                cmd.finish    = stat.div_done;
            end
            rau_pkg::S_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: cross products, binary gcd, restoring division, result format.
// ----------------------------------------------------------------------------
module rau_dp
#(
    parameter int WIDTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rau_pkg::rau_cmd_t         cmd,
    output rau_pkg::rau_stat_t        stat,
    input  logic [2:0]                mode,
    input  logic signed [WIDTH-1:0]   a_num,
    input  logic signed [WIDTH-1:0]   a_den,
    input  logic signed [WIDTH-1:0]   b_num,
    input  logic signed [WIDTH-1:0]   b_den,
    output logic signed [WIDTH-1:0]   res_num,
    output logic [WIDTH-2:0]          res_den,
    output logic                      is_true,
    output logic [1:0]                status
);

    localparam int PW = 2 * WIDTH + 1;  // magnitude of sum of two products
    localparam int CW = $clog2(PW + 1);
    localparam int SW = $clog2(PW + 1);

    logic [2:0]           mode_reg;
    logic signed [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;

    // operand magnitudes and signs
    logic [WIDTH-1:0] m_an, m_ad, m_bn, m_bd;
    logic s_an, s_ad, s_bn, s_bd;
    logic [2*WIDTH-1:0] p1, p2, pd;
    logic sp1, sp2, spd;
    logic [PW-1:0] nmag, dmag;
    logic nneg, dneg;
    logic zero_den;

    logic [PW-1:0] n_reg, d_reg;        // raw magnitudes
    logic          sneg_reg;
    logic [PW-1:0] gx_reg, gy_reg;      // gcd working values
    logic [SW-1:0] gsh_reg;             // common factors of two
    logic [PW-1:0] g_reg;
    logic [PW-1:0] q_reg, r_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] rn_reg;

    logic signed [WIDTH-1:0] res_num_reg;
    logic [WIDTH-2:0]        res_den_reg;
    logic                    is_true_reg;
    logic [1:0]              status_reg;

    function automatic logic [WIDTH-1:0] mag_f(input logic signed [WIDTH-1:0] v);
        mag_f = v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb
    begin
        m_an = mag_f(an_reg);
        m_ad = mag_f(ad_reg);
        m_bn = mag_f(bn_reg);
        m_bd = mag_f(bd_reg);
        s_an = an_reg[WIDTH-1];
        s_ad = ad_reg[WIDTH-1];
        s_bn = bn_reg[WIDTH-1];
        s_bd = bd_reg[WIDTH-1];
        zero_den = (ad_reg == '0)
                 || ((mode_reg != rau_pkg::MODE_NEG) && (bd_reg == '0))
                 || ((mode_reg == rau_pkg::MODE_DIV) && (bn_reg == '0));
        p1 = '0; p2 = '0; pd = '0; sp1 = 1'b0; sp2 = 1'b0; spd = 1'b0;
        unique case (mode_reg)
            rau_pkg::MODE_MUL:
            begin
                p1 = m_an * m_bn; sp1 = s_an ^ s_bn;
                pd = m_ad * m_bd; spd = s_ad ^ s_bd;
            end
            rau_pkg::MODE_DIV:
            begin
                p1 = m_an * m_bd; sp1 = s_an ^ s_bd;
                pd = m_bn * m_ad; spd = s_bn ^ s_ad;
            end
            rau_pkg::MODE_NEG:
            begin
                p1 = {{WIDTH{1'b0}}, m_an}; sp1 = !s_an;
                pd = {{WIDTH{1'b0}}, m_ad}; spd = s_ad;
            end
            rau_pkg::MODE_SUB, rau_pkg::MODE_EQ, rau_pkg::MODE_NE:
            begin
                p1 = m_an * m_bd; sp1 = s_an ^ s_bd;
                p2 = m_bn * m_ad; sp2 = !(s_bn ^ s_ad);
                pd = m_ad * m_bd; spd = s_ad ^ s_bd;
            end
            default:
            begin
                p1 = m_an * m_bd; sp1 = s_an ^ s_bd;
                p2 = m_bn * m_ad; sp2 = s_bn ^ s_ad;
                pd = m_ad * m_bd; spd = s_ad ^ s_bd;
            end
        endcase
        if (sp1 == sp2)
        begin
            nmag = {1'b0, p1} + {1'b0, p2};
            nneg = sp1;
        end
        else if (p1 >= p2)
        begin
            nmag = {1'b0, p1} - {1'b0, p2};
            nneg = sp1;
        end
        else
        begin
            nmag = {1'b0, p2} - {1'b0, p1};
            nneg = sp2;
        end
        dmag = {1'b0, pd};
        dneg = spd;
    end

    // binary gcd step: strip common twos, halve an even value, else halve the odd difference
    logic [PW-1:0] gdiff;
    logic          gdone;
    assign gdone = (gy_reg == '0) || (gx_reg == '0);
    assign gdiff = (gx_reg >= gy_reg) ? (gx_reg - gy_reg) : (gy_reg - gx_reg);

    // division step
    logic [PW:0]   rsh;
    logic [PW:0]   rsub;
    assign rsh  = {r_reg, q_reg[PW-1]};
    assign rsub = rsh - {1'b0, g_reg};

    assign stat.gcd_done = gdone;
    assign stat.div_done = (cnt_reg == CW'(PW));
    assign stat.early    = 1'b0;

    // reduced numerator/denominator checks
    localparam logic [PW-1:0] LIM = PW'(1) << (WIDTH - 1);
    logic rneg;
    logic ovf;
    assign rneg = (rn_reg != '0) && sneg_reg;
    assign ovf  = (rneg ? (rn_reg > LIM) : (rn_reg >= LIM)) || (q_reg >= LIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
        end
        if (cmd.mul)
        begin
            n_reg    <= nmag;
            d_reg    <= dmag;
            sneg_reg <= nneg ^ dneg;
            gsh_reg  <= '0;
            res_num_reg <= '0;
            res_den_reg <= '0;
            is_true_reg <= 1'b0;
            status_reg  <= rau_pkg::ST_OK;
            // gcd(0,d)=d handled by loop exit on zero operand
            gx_reg <= nmag;
            gy_reg <= dmag;
            if (mode_reg == rau_pkg::MODE_NOP)
            begin
                gx_reg <= '0;
            end
            else if (zero_den)
            begin
                status_reg <= rau_pkg::ST_ZERO_DEN;
                gx_reg <= '0;
            end
            else if (mode_reg == rau_pkg::MODE_EQ || mode_reg == rau_pkg::MODE_NE)
            begin
                is_true_reg <= (nmag == '0) ^ (mode_reg == rau_pkg::MODE_NE);
                gx_reg <= '0;
            end
        end
        if (cmd.gcd_step)
        begin
            if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg  <= gx_reg >> 1;
                gy_reg  <= gy_reg >> 1;
                gsh_reg <= gsh_reg + 1'b1;
            end
            else if (!gx_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
            end
            else if (!gy_reg[0])
            begin
                gy_reg <= gy_reg >> 1;
            end
            else if (gx_reg >= gy_reg)
            begin
                gx_reg <= gdiff >> 1;
            end
            else
            begin
                gy_reg <= gdiff >> 1;
            end
        end
        if (cmd.div_init)
        begin
            if (!cmd.div_sel_d)
            begin
                g_reg <= (gx_reg | gy_reg) << gsh_reg;
                q_reg <= n_reg;
            end
            else
            begin
                rn_reg <= q_reg;
                q_reg  <= d_reg;
            end
            r_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rsub[PW])
            begin
                r_reg <= rsub[PW-1:0];
                q_reg <= {q_reg[PW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= rsh[PW-1:0];
                q_reg <= {q_reg[PW-2:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            if (status_reg == rau_pkg::ST_OK && mode_reg != rau_pkg::MODE_NOP
                && mode_reg != rau_pkg::MODE_EQ && mode_reg != rau_pkg::MODE_NE)
            begin
                if (ovf)
                begin
                    status_reg <= rau_pkg::ST_OVERFLOW;
                end
                else
                begin
                    res_num_reg <= rneg ? WIDTH'(~rn_reg + 1'b1) : WIDTH'(rn_reg);
                    res_den_reg <= q_reg[WIDTH-2:0];
                end
            end
        end
    end

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign is_true = is_true_reg;
    assign status  = status_reg;

endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// Sequence from input accept to out_valid: multiply, binary-gcd steps, then two
// restoring divisions by the gcd, first of the numerator, then of the denominator.
// One item at a time: a new input is accepted only after the result has been taken.
// Special cases (zero denominator, compare, no-op) skip the gcd steps only.
// Reset: rst_n async active low returns the sequencer to idle, output empty.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Two-fraction arithmetic with gcd reduction, valid/ready on both sides.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
#(
    parameter int WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              mode,
    input  logic signed [WIDTH-1:0] a_num,
    input  logic signed [WIDTH-1:0] a_den,
    input  logic signed [WIDTH-1:0] b_num,
    input  logic signed [WIDTH-1:0] b_den,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [WIDTH-1:0] res_num,
    output logic [WIDTH-2:0]        res_den,
    output logic                    is_true,
    output logic [1:0]              status
);

    rau_pkg::rau_cmd_t  cmd;
    rau_pkg::rau_stat_t stat;

    rau_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rau_dp #(.WIDTH(WIDTH)) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .mode    (mode),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .res_num (res_num),
        .res_den (res_den),
        .is_true (is_true),
        .status  (status)
    );

endmodule

// File: rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_checker
#(
    parameter int WIDTH = 16
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [WIDTH-1:0] res_num,
    input logic [WIDTH-2:0] res_den,
    input logic             is_true,
    input logic [1:0]       status
);

    // one item in flight: no acceptance while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(status))
        else $error("result changed while stalled");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != rau_pkg::ST_OK |-> res_num == '0 && res_den == '0)
        else $error("error result carries data");

    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == rau_pkg::ST_OK || status == rau_pkg::ST_ZERO_DEN
                       || status == rau_pkg::ST_OVERFLOW)
                      && !(is_true && res_den != '0))
        else $error("bad status or mixed result");

endmodule

bind rational_arithmetic_unit rau_checker #(.WIDTH(WIDTH)) u_rau_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_num   (res_num),
    .res_den   (res_den),
    .is_true   (is_true),
    .status    (status)
);
